@@ rtl/ukl_pkg.sv @@
// Shared types and constants of the unordered key list table.
`timescale 1ns / 1ps

package ukl_pkg;

  localparam int unsigned CAPACITY_DEF = 8;
  localparam int unsigned KEY_W        = 32;
  localparam int unsigned STATUS_W     = 3;
  localparam int unsigned POS_W        = 4;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_ALTER  = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_DUPLICATE = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_EMPTY     = 3'd3,
    STAT_NOTFOUND  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_SHIFT,
    S_DONE
  } state_e;

  typedef struct packed {
    status_e            status;
    logic [POS_W-1:0]   position;
    logic [POS_W-1:0]   entry_count;
  } res_t;

endpackage

@@ rtl/ukl_mem.sv @@
// Key store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module ukl_mem #(
  parameter int unsigned DEPTH = ukl_pkg::CAPACITY_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk_i,
  input  logic                        rd_en_i,
  input  logic [AW-1:0]               rd_addr_i,
  output logic [ukl_pkg::KEY_W-1:0]   rd_data_o,
  input  logic                        wr_en_i,
  input  logic [AW-1:0]               wr_addr_i,
  input  logic [ukl_pkg::KEY_W-1:0]   wr_data_i
);
  import ukl_pkg::*;

  logic [KEY_W-1:0] mem [DEPTH];
  logic [KEY_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/ukl_ctrl.sv @@
// Request sequencer: scans the key store, then inserts, alters or shifts entries down.
`timescale 1ns / 1ps

module ukl_ctrl #(
  parameter int unsigned CAPACITY = ukl_pkg::CAPACITY_DEF,
  parameter int unsigned AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  ukl_pkg::kind_e              kind_i,
  input  logic [ukl_pkg::KEY_W-1:0]   key_i,
  input  logic [ukl_pkg::KEY_W-1:0]   new_key_i,
  output logic                        res_valid_o,
  input  logic                        res_take_i,
  output ukl_pkg::res_t               res_o,
  output logic                        rd_en_o,
  output logic [AW-1:0]               rd_addr_o,
  input  logic [ukl_pkg::KEY_W-1:0]   rd_data_i,
  output logic                        wr_en_o,
  output logic [AW-1:0]               wr_addr_o,
  output logic [ukl_pkg::KEY_W-1:0]   wr_data_o
);
  import ukl_pkg::*;

  state_e           state_q, state_d;
  kind_e            kind_q, kind_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [KEY_W-1:0] nkey_q, nkey_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic [AW-1:0]    wptr_q, wptr_d;
  logic             rvld_q, rvld_d;
  status_e          status_q, status_d;

  logic in_acc;
  logic hit;
  logic scan_end;
  logic found;
  logic do_shift;
  logic shift_end;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign hit       = rvld_q && (rd_data_i == key_q);
  assign scan_end  = hit || (idx_q == cnt_q);
  assign found     = (pos_q != '0);
  assign do_shift  = (kind_q == KIND_DELETE) && found;
  assign shift_end = (idx_q == cnt_q) && !rvld_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_SCAN;
      S_SCAN:  if (scan_end) state_d = S_ACT;
      S_ACT:   state_d = do_shift ? S_SHIFT : S_DONE;
      S_SHIFT: if (shift_end) state_d = S_DONE;
      S_DONE:  if (res_take_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    in_stall_o  = (state_q != S_IDLE);
    res_valid_o = (state_q == S_DONE);
    rd_en_o     = 1'b0;
    rd_addr_o   = idx_q[AW-1:0];
    wr_en_o     = 1'b0;
    wr_addr_o   = wptr_q;
    wr_data_o   = key_q;
    kind_d      = kind_q;
    key_d       = key_q;
    nkey_d      = nkey_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    wptr_d      = wptr_q;
    rvld_d      = 1'b0;
    status_d    = status_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          kind_d = kind_i;
          key_d  = key_i;
          nkey_d = new_key_i;
          idx_d  = '0;
        end
      end
      S_SCAN: begin
        if (hit) begin
          pos_d = idx_q;
        end else if (idx_q == cnt_q) begin
          pos_d = '0;
        end else begin
          rd_en_o = 1'b1;
          idx_d   = idx_q + 1'b1;
          rvld_d  = 1'b1;
        end
      end
      S_ACT: begin
        status_d = STAT_OK;
        case (kind_q)
          KIND_INSERT: begin
            if (cnt_q == CNT_W'(CAPACITY)) begin
              status_d = STAT_FULL;
              pos_d    = '0;
            end else if (found) begin
              status_d = STAT_DUPLICATE;
            end else begin
              wr_en_o   = 1'b1;
              wr_addr_o = cnt_q[AW-1:0];
              wr_data_o = key_q;
              cnt_d     = cnt_q + 1'b1;
              pos_d     = cnt_q + 1'b1;
            end
          end
          KIND_SEARCH: begin
            if (!found) status_d = STAT_NOTFOUND;
          end
          KIND_DELETE: begin
            if (cnt_q == '0) begin
              status_d = STAT_EMPTY;
            end else if (!found) begin
              status_d = STAT_NOTFOUND;
            end else begin
              idx_d  = pos_q;
              wptr_d = AW'(pos_q - 1'b1);
            end
          end
          KIND_ALTER: begin
            if (cnt_q == '0) begin
              status_d = STAT_EMPTY;
            end else if (!found) begin
              status_d = STAT_NOTFOUND;
            end else begin
              wr_en_o   = 1'b1;
              wr_addr_o = AW'(pos_q - 1'b1);
              wr_data_o = nkey_q;
            end
          end
          default: status_d = STAT_OK;
        endcase
      end
      S_SHIFT: begin
        // Write back the entry read last cycle one slot lower.
        if (rvld_q) begin
          wr_en_o   = 1'b1;
          wr_addr_o = wptr_q;
          wr_data_o = rd_data_i;
          wptr_d    = wptr_q + 1'b1;
        end
        if (idx_q != cnt_q) begin
          rd_en_o = 1'b1;
          idx_d   = idx_q + 1'b1;
          rvld_d  = 1'b1;
        end else if (!rvld_q) begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign res_o.status      = status_q;
  assign res_o.position    = POS_W'(pos_q);
  assign res_o.entry_count = POS_W'(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      rvld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rvld_q  <= rvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    key_q    <= key_d;
    nkey_q   <= nkey_d;
    idx_q    <= idx_d;
    pos_q    <= pos_d;
    wptr_q   <= wptr_d;
    status_q <= status_d;
  end

endmodule

@@ rtl/unordered_key_list_table.sv @@
// Top level of the unordered key list table: sequencer, key store and result register.
`timescale 1ns / 1ps

// Keeps an unordered, compact list of up to CAPACITY signed 32-bit keys in
// a single-port-read synchronous memory, plus an entry count. Each item is
// an insert, search, delete or alter request and yields exactly one result
// item with a status, a 1-based position and the entry count after the
// request. One request is in flight at a time. The key store has one
// read port, so the scan for the key reads one entry per cycle, and a
// delete then walks the remaining entries once more to close the gap
// (one read and one write per cycle, overlapped). Insert and alter write
// a single entry. The result sits in an output register, so the next
// item is taken while a result still waits downstream. Reset clears only
// the count, the state and the valid flags; the store content is never
// read beyond the count, so it needs no clearing.

module unordered_key_list_table #(
  parameter int unsigned CAPACITY = ukl_pkg::CAPACITY_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     kind_i,
  input  logic signed [ukl_pkg::KEY_W-1:0] key_i,
  input  logic signed [ukl_pkg::KEY_W-1:0] new_key_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [ukl_pkg::STATUS_W-1:0]   status_o,
  output logic [ukl_pkg::POS_W-1:0]      position_o,
  output logic [ukl_pkg::POS_W-1:0]      entry_count_o
);
  import ukl_pkg::*;

  localparam int unsigned AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // Key store port wiring
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [KEY_W-1:0] rd_data;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [KEY_W-1:0] wr_data;

  // Result hand-off from the sequencer
  logic res_valid;
  logic res_take;
  res_t res;

  // Output register
  logic out_valid_q, out_valid_d;
  res_t out_q;

  ukl_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_e'(kind_i)),
    .key_i       (key_i),
    .new_key_i   (new_key_i),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  ukl_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // Move a finished result into the output register whenever it is empty
  // or being drained this cycle; otherwise hold it in the sequencer.
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign position_o    = out_q.position;
  assign entry_count_o = out_q.entry_count;

endmodule

@@ bench/unordered_key_list_table_test.sv @@
// Self-checking testbench of the unordered key list table.
`timescale 1ns / 1ps

module unordered_key_list_table_test;
  import ukl_pkg::*;

  localparam int unsigned LIST_DEPTH   = CAPACITY_DEF;
  // Longest run of cycles with no item moving on either side before giving up.
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned RANDOM_ITEMS = 1530;
  // Cycles to wait after the last result: one full request plus margin.
  localparam int unsigned TAIL_CYCLES  = CAPACITY_DEF + 10;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  logic [1:0]             kind_i      = '0;
  logic signed [KEY_W-1:0] key_i      = '0;
  logic signed [KEY_W-1:0] new_key_i  = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [STATUS_W-1:0]    status_o;
  logic [POS_W-1:0]       position_o;
  logic [POS_W-1:0]       entry_count_o;

  // Shadow copy of the list: keys in slots 0..shadow_count-1.
  logic [KEY_W-1:0] shadow_keys [LIST_DEPTH];
  int unsigned      shadow_count = 0;
  res_t             pending_results [$];

  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  int unsigned stall_hold     = 0;
  int unsigned kind_seen [4]  = '{default: 0};
  int unsigned status_seen [5] = '{default: 0};
  bit          no_idle        = 1'b0;

  unordered_key_list_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .key_i         (key_i),
    .new_key_i     (new_key_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .position_o    (position_o),
    .entry_count_o (entry_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // List predictor
  // ---------------------------------------------------------------------------

  // Return the 1-based slot of the first matching key, 0 when absent.
  function automatic int unsigned find_shadow(logic [KEY_W-1:0] k);
    for (int unsigned i = 0; i < shadow_count; i++) begin
      if (shadow_keys[i] == k) return i + 1;
    end
    return 0;
  endfunction

  // Apply one request to the shadow list and return the result it must give.
  function automatic res_t apply_list_request(kind_e k, logic [KEY_W-1:0] key,
                                              logic [KEY_W-1:0] nk);
    res_t        r;
    int unsigned pos;
    r.status = STAT_OK;
    pos = 0;
    case (k)
      KIND_INSERT: begin
        // Full wins over duplicate.
        if (shadow_count >= LIST_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          pos = find_shadow(key);
          if (pos != 0) begin
            r.status = STAT_DUPLICATE;
          end else begin
            shadow_keys[shadow_count] = key;
            shadow_count++;
            pos = shadow_count;
          end
        end
      end
      KIND_SEARCH: begin
        pos = find_shadow(key);
        if (pos == 0) r.status = STAT_NOTFOUND;
      end
      KIND_DELETE: begin
        if (shadow_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          pos = find_shadow(key);
          if (pos == 0) begin
            r.status = STAT_NOTFOUND;
          end else begin
            // Close the gap: shift every later key down one slot.
            for (int unsigned i = pos - 1; i + 1 < shadow_count; i++) begin
              shadow_keys[i] = shadow_keys[i + 1];
            end
            shadow_count--;
          end
        end
      end
      default: begin
        // Alter: overwrite in place, no duplicate check.
        if (shadow_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          pos = find_shadow(key);
          if (pos == 0) r.status = STAT_NOTFOUND;
          else shadow_keys[pos - 1] = nk;
        end
      end
    endcase
    r.position    = pos[POS_W-1:0];
    r.entry_count = shadow_count[POS_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly back-to-back, sometimes short gaps, rarely long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Small pool of keys so that inserts collide and searches hit.
  function automatic logic [KEY_W-1:0] pool_key();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return 32'(int'($urandom_range(0, 11)) - 6);
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] pick_key(bit prefer_stored);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (prefer_stored && shadow_count != 0 && r < 55) begin
      return shadow_keys[$urandom_range(0, shadow_count - 1)];
    end
    if (r < 85) return pool_key();
    return $urandom();
  endfunction

  // Present one item, hold it until taken, then record what it must return.
  task automatic send_item(kind_e k, logic [KEY_W-1:0] key, logic [KEY_W-1:0] nk);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= k;
    key_i      <= key;
    new_key_i  <= nk;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(apply_list_request(k, key, nk));
    kind_seen[k]++;
  endtask

  // Hold the sender until every outstanding result has come back.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall with long and short stretches
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (no_idle) begin
      out_stall_i <= 1'b0;
      stall_hold = 0;
    end else if (stall_hold != 0) begin
      stall_hold--;
    end else if ($urandom_range(0, 99) < 40) begin
      out_stall_i <= 1'b1;
      stall_hold = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                : $urandom_range(8, 40);
    end else begin
      out_stall_i <= 1'b0;
      stall_hold = $urandom_range(0, 6);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker and watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("unordered_key_list_table: mismatch");
        $finish;
      end
      if (out_valid_o && !out_stall_i) begin
        if (status_o < 5) status_seen[status_o]++;
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: status %0d position %0d entry_count %0d",
                 status_o, position_o, entry_count_o);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            mismatch_count++;
          end
          if (position_o !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, position_o);
            mismatch_count++;
          end
          if (entry_count_o !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, entry_count_o);
            mismatch_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Search, delete and alter against a list that holds nothing.
  task automatic test_empty_list();
    send_item(KIND_SEARCH, 32'h0000_0000, 32'h0000_0000);
    send_item(KIND_DELETE, 32'h7FFF_FFFF, 32'h0000_0000);
    send_item(KIND_ALTER,  32'h8000_0000, 32'hFFFF_FFFF);
  endtask

  // Fill every slot with extreme and patterned keys, then insert past the end.
  task automatic test_fill_to_capacity();
    send_item(KIND_INSERT, 32'h8000_0000, 32'h0000_0000);
    send_item(KIND_INSERT, 32'h7FFF_FFFF, 32'h0000_0000);
    send_item(KIND_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_item(KIND_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(KIND_INSERT, 32'h0000_0001, 32'h0000_0000);
    send_item(KIND_INSERT, 32'h5555_5555, 32'h0000_0000);
    send_item(KIND_INSERT, 32'hAAAA_AAAA, 32'h0000_0000);
    send_item(KIND_INSERT, 32'h1234_5678, 32'h0000_0000);
    send_item(KIND_INSERT, 32'h0BAD_F00D, 32'h0000_0000);
    // A key already present still reports full once the list is full.
    send_item(KIND_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
  endtask

  // Delete from the middle, delete something absent, reinsert a duplicate.
  task automatic test_delete_and_duplicate();
    send_item(KIND_DELETE, 32'h0000_0000, 32'h0000_0000);
    send_item(KIND_DELETE, 32'h0000_0002, 32'h0000_0000);
    send_item(KIND_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
  endtask

  // Search first, last, absent keys; alter to a duplicate, search it; alter absent; delete.
  task automatic test_search_and_alter();
    send_item(KIND_SEARCH, 32'h8000_0000, 32'h0000_0000);
    send_item(KIND_SEARCH, 32'h1234_5678, 32'h0000_0000);
    send_item(KIND_SEARCH, 32'h0000_0002, 32'h0000_0000);
    send_item(KIND_ALTER,  32'h0000_0001, 32'h7FFF_FFFF);
    send_item(KIND_SEARCH, 32'h7FFF_FFFF, 32'h0000_0000);
    send_item(KIND_ALTER,  32'h0000_0003, 32'h0000_0000);
    send_item(KIND_DELETE, 32'h8000_0000, 32'h0000_0000);
  endtask

  // Random traffic in phases that lean toward filling or draining the list.
  task automatic test_random_traffic();
    int unsigned insert_pct;
    kind_e       k;
    insert_pct = 50;
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0:       insert_pct = 70;
          1:       insert_pct = 40;
          default: insert_pct = 15;
        endcase
        no_idle = ($urandom_range(0, 4) == 0);
      end
      // Drain the whole pipeline once in the middle of the run.
      if (n == RANDOM_ITEMS / 2) wait_for_results();
      if ($urandom_range(0, 99) < insert_pct) begin
        k = KIND_INSERT;
      end else begin
        case ($urandom_range(0, 2))
          0:       k = KIND_SEARCH;
          1:       k = KIND_DELETE;
          default: k = KIND_ALTER;
        endcase
      end
      send_item(k, pick_key(k != KIND_INSERT),
                $urandom_range(0, 1) ? pool_key() : logic'($urandom()) ? $urandom() : $urandom());
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_list();
    test_fill_to_capacity();
    test_delete_and_duplicate();
    test_search_and_alter();
    test_random_traffic();

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d insert, %0d search, %0d delete and %0d alter requests",
             kind_seen[KIND_INSERT], kind_seen[KIND_SEARCH],
             kind_seen[KIND_DELETE], kind_seen[KIND_ALTER]);
    $display("statuses returned: ok %0d, duplicate %0d, full %0d, empty %0d, not found %0d",
             status_seen[STAT_OK], status_seen[STAT_DUPLICATE], status_seen[STAT_FULL],
             status_seen[STAT_EMPTY], status_seen[STAT_NOTFOUND]);
    if (mismatch_count == 0) begin
      $display("unordered_key_list_table: match");
    end else begin
      $display("unordered_key_list_table: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ukl_pkg.sv
rtl/ukl_mem.sv
rtl/ukl_ctrl.sv
rtl/unordered_key_list_table.sv
bench/unordered_key_list_table_test.sv
